// File: src/prl_pkg.sv
package prl_pkg;

  localparam int CapacityDef = 64;
  localparam int PosW        = 11;
  localparam int FieldW      = 16;

  typedef enum logic [2:0] {
    MODE_ADD_HEAD = 3'd0,
    MODE_ADD_TAIL = 3'd1,
    MODE_INSERT   = 3'd2,
    MODE_DEL_HEAD = 3'd3,
    MODE_DEL_TAIL = 3'd4,
    MODE_DEL_AT   = 3'd5,
    MODE_READ     = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_RD_LOAD,
    CELL_RD_SHIFT
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [FieldW-1:0] carriage;
    logic [FieldW-1:0] seats;
    logic [FieldW-1:0] limit;
    logic [FieldW-1:0] count;
  } rec_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e op;
    rec_t     rec;
  } cell_ctrl_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] size;
    rec_t            rd;
  } result_t;

endpackage

// File: src/prl_cell.sv
module prl_cell import prl_pkg::*; #(
  parameter int IdxW = 6,
  parameter int Idx  = 0
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [IdxW-1:0] idx_i,
  input  rec_t            left_i,
  input  rec_t            right_i,
  input  rec_t            bus_right_i,
  output rec_t            rec_o,
  output rec_t            bus_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  rec_t rec_q, rec_d;
  rec_t bus_q, bus_d;

  always_comb begin
    rec_d = rec_q;
    bus_d = bus_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyIdx > idx_i) begin
          rec_d = left_i;
        end else if (MyIdx == idx_i) begin
          rec_d = ctrl_i.rec;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= idx_i) begin
          rec_d = right_i;
        end
      end
      CELL_RD_LOAD: begin
        bus_d = (MyIdx == idx_i) ? rec_q : '0;
      end
      CELL_RD_SHIFT: begin
        bus_d = bus_right_i;
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    bus_q <= bus_d;
  end

  assign rec_o = rec_q;
  assign bus_o = bus_q;

endmodule

// File: src/positional_record_list.sv
// Add, insert and delete: result registered on accept; a new item may follow unless the skid
// entry is full. Read at position p (valid): the record of cell p-1 walks down the chain of
// cells one place per cycle toward cell 0, where it is the result; out of range: result on accept.
// One result may wait on a stalled output while the next item is accepted.
// Reset clears the list size and handshake state; record contents are not cleared.
module positional_record_list import prl_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        mode_i,
  input  logic [PosW-1:0]   position_i,
  input  logic [FieldW-1:0] carriage_id_i,
  input  logic [FieldW-1:0] seat_count_i,
  input  logic [FieldW-1:0] passenger_limit_i,
  input  logic [FieldW-1:0] passenger_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [PosW-1:0]   list_size_o,
  output logic [FieldW-1:0] read_carriage_id_o,
  output logic [FieldW-1:0] read_seat_count_o,
  output logic [FieldW-1:0] read_passenger_limit_o,
  output logic [FieldW-1:0] read_passenger_count_o
);

  localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SizeW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;

  cell_ctrl_t      ctrl;
  logic [IdxW-1:0] cell_idx;
  result_t         res;
  logic            res_valid;

  result_t out_q, pend_q;
  logic    out_valid_q, pend_valid_q;

  rec_t cell_rec [CAPACITY];
  rec_t cell_bus [CAPACITY];
  rec_t new_rec;

  logic            in_acc;
  logic [PosW-1:0] size_ext;
  logic            is_full, is_empty, ins_pos_ok, sel_pos_ok;
  logic [IdxW-1:0] pos_idx;

  assign in_stall_o = (state_q != S_IDLE) || pend_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign new_rec = '{carriage: carriage_id_i, seats: seat_count_i,
                     limit: passenger_limit_i, count: passenger_count_i};

  assign size_ext   = PosW'(size_q);
  assign is_full    = (size_q == SizeW'(CAPACITY));
  assign is_empty   = (size_q == '0);
  assign ins_pos_ok = (position_i != '0) && (position_i <= size_ext + PosW'(1));
  assign sel_pos_ok = (position_i != '0) && (position_i <= size_ext);
  assign pos_idx    = IdxW'(position_i - PosW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && mode_e'(mode_i) == MODE_READ && sel_pos_ok) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (cnt_q == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Decode and chain control
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.rec   = new_rec;
    cell_idx   = '0;
    size_d     = size_q;
    cnt_d      = cnt_q;
    res_valid  = 1'b0;
    res.status = STATUS_OK;
    res.size   = size_ext;
    res.rd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_valid = 1'b1;
          case (mode_e'(mode_i))
            MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_INSERT: begin
              if (is_full) begin
                res.status = STATUS_FULL;
              end else if (mode_e'(mode_i) == MODE_INSERT && !ins_pos_ok) begin
                res.status = STATUS_BAD_POS;
              end else begin
                ctrl.op  = CELL_INSERT;
                size_d   = size_q + SizeW'(1);
                res.size = PosW'(size_d);
                case (mode_e'(mode_i))
                  MODE_ADD_HEAD: cell_idx = '0;
                  MODE_ADD_TAIL: cell_idx = IdxW'(size_q);
                  default:       cell_idx = pos_idx;
                endcase
              end
            end
            MODE_DEL_HEAD, MODE_DEL_TAIL, MODE_DEL_AT: begin
              if (is_empty) begin
                res.status = STATUS_EMPTY;
              end else if (mode_e'(mode_i) == MODE_DEL_AT && !sel_pos_ok) begin
                res.status = STATUS_BAD_POS;
              end else begin
                ctrl.op  = CELL_DELETE;
                size_d   = size_q - SizeW'(1);
                res.size = PosW'(size_d);
                case (mode_e'(mode_i))
                  MODE_DEL_HEAD: cell_idx = '0;
                  MODE_DEL_TAIL: cell_idx = IdxW'(size_q - SizeW'(1));
                  default:       cell_idx = pos_idx;
                endcase
              end
            end
            MODE_READ: begin
              if (sel_pos_ok) begin
                // result comes once the record has walked down to cell 0
                res_valid = 1'b0;
                ctrl.op   = CELL_RD_LOAD;
                cell_idx  = pos_idx;
                cnt_d     = pos_idx;
              end else begin
                res.status = STATUS_BAD_POS;
              end
            end
            default: res.status = STATUS_BAD_POS;
          endcase
        end
      end
      S_READ: begin
        if (cnt_q == '0) begin
          res_valid = 1'b1;
          res.rd    = cell_bus[0];
        end else begin
          ctrl.op = CELL_RD_SHIFT;
          cnt_d   = cnt_q - IdxW'(1);
        end
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left, right, bus_right;
    if (i == 0) begin : g_first
      assign left = new_rec;
    end else begin : g_mid_l
      assign left = cell_rec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right     = cell_rec[i];
      assign bus_right = '0;
    end else begin : g_mid_r
      assign right     = cell_rec[i+1];
      assign bus_right = cell_bus[i+1];
    end
    prl_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .idx_i       (cell_idx),
      .left_i      (left),
      .right_i     (right),
      .bus_right_i (bus_right),
      .rec_o       (cell_rec[i]),
      .bus_o       (cell_bus[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register plus one skid entry
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= res_valid;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
        if (res_valid) begin
          pend_q <= res;
        end
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      pend_q <= res;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign status_o               = out_q.status;
  assign list_size_o            = out_q.size;
  assign read_carriage_id_o     = out_q.rd.carriage;
  assign read_seat_count_o      = out_q.rd.seats;
  assign read_passenger_limit_o = out_q.rd.limit;
  assign read_passenger_count_o = out_q.rd.count;

endmodule
